FILE: rtl/all_simple_paths_enumerator_assert.svh
// Assertion macros for the all simple paths enumerator checker.
// Depends on nothing; included by the checker file only.
`ifndef ALL_SIMPLE_PATHS_ENUMERATOR_ASSERT_SVH
`define ALL_SIMPLE_PATHS_ENUMERATOR_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define ASP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/asp_pkg.sv
// Shared types and constants for the all simple paths enumerator.
// Used by the controller, the datapath, the top level and the checker.
package asp_pkg;

   localparam logic [1:0] CMD_ADD_EDGE  = 2'd0;
   localparam logic [1:0] CMD_CLEAR     = 2'd1;
   localparam logic [1:0] CMD_NEXT_PATH = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_VERTEX = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_VERTEX = 2'd2;

   localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] from_vertex;
      logic [3:0] to_vertex;
   } req_type;

   typedef struct packed {
      logic [3:0] vertex_index;
      logic       last_of_path;
      logic       done_res;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_NOT_STARTED,
      PH_RESUME,
      PH_FINISHED
   } walk_phase_type;

   typedef struct packed {
      logic adj_add;
      logic adj_clear;
      logic walk_start;
      logic walk_pop;
      logic walk_step;
      logic rd_emit;
      logic out_path;
      logic out_done;
   } dp_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic endpoint_bad;
      logic src_is_tgt;
      logic stack_empty;
      logic hit_target;
      logic emit_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/asp_ctrl.sv
// Controller state machine for the path enumerator: sequences start, search and output.
// Depends on asp_pkg for the state, phase, command and status types.
module asp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_command,
   output logic                  req_stall,
   input  asp_pkg::dp_status_type status,
   output asp_pkg::dp_cmd_type    cmd
);
   import asp_pkg::*;

   ctrl_state_type state_ff, state_in;
   walk_phase_type phase_ff, phase_in;
   logic           req_accept;

   assign req_accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.cfg_write) begin
               phase_in = PH_NOT_STARTED;
            end
            if (req_accept) begin
               case (req_command)
                  CMD_ADD_EDGE, CMD_CLEAR: begin
                     phase_in = PH_NOT_STARTED;
                  end
                  CMD_NEXT_PATH: begin
                     case (phase_ff)
                        PH_FINISHED: state_in = ST_DONE;
                        PH_RESUME:   state_in = ST_SEARCH;
                        PH_NOT_STARTED: begin
                           if (status.endpoint_bad) begin
                              state_in = ST_DONE;
                           end else if (status.src_is_tgt) begin
                              state_in = ST_EMIT;
                           end else begin
                              state_in = ST_SEARCH;
                           end
                        end
                        default: state_in = ST_IDLE;
                     endcase
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (status.stack_empty) begin
               state_in = ST_DONE;
            end else if (status.hit_target) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               phase_in = PH_RESUME;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               phase_in = PH_FINISHED;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               case (req_command)
                  CMD_ADD_EDGE: cmd.adj_add   = 1'b1;
                  CMD_CLEAR:    cmd.adj_clear = 1'b1;
                  CMD_NEXT_PATH: begin
                     cmd.walk_start = (phase_ff == PH_NOT_STARTED) && !status.endpoint_bad;
                     cmd.walk_pop   = (phase_ff == PH_RESUME);
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_SEARCH: cmd.walk_step = !status.stack_empty;
         ST_EMIT: begin
            cmd.rd_emit  = 1'b1;
            cmd.out_path = status.out_free;
         end
         ST_DONE: cmd.out_done = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_NOT_STARTED;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: rtl/asp_datapath.sv
// Datapath for the path enumerator: registers, adjacency rows, walk stack and output beat.
// Depends on asp_pkg; driven by asp_ctrl through command and status structs.
module asp_datapath #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  asp_pkg::req_type                    req_data,
   input  logic                                csr_we,
   input  logic [asp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [asp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  asp_pkg::dp_cmd_type                 cmd,
   output asp_pkg::dp_status_type              status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output asp_pkg::rsp_type                    rsp_data
);
   import asp_pkg::*;

   localparam int NV = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int VW = $clog2(NV);
   localparam int CW = $clog2(NV + 1);

   logic [4:0]    vertex_count_ff, vertex_count_in;
   logic [3:0]    source_ff, source_in;
   logic [3:0]    target_ff, target_in;
   logic [NV-1:0] adj_ff [NV];
   logic [NV-1:0] adj_in [NV];
   logic [NV-1:0] visited_ff, visited_in;
   logic [VW-1:0] stack_ff [NV];
   logic [VW-1:0] stack_in [NV];
   logic [CW-1:0] cursor_ff [NV];
   logic [CW-1:0] cursor_in [NV];
   logic [CW-1:0] depth_ff, depth_in;
   logic [VW-1:0] emit_ff, emit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [CW-1:0] live_n;
   logic [CW-1:0] depth_m1;
   logic [VW-1:0] top_idx;
   logic [VW-1:0] push_idx;
   logic [VW-1:0] rd_idx;
   logic [VW-1:0] rd_vertex;
   logic [NV-1:0] row;
   logic [CW-1:0] cur;
   logic [NV-1:0] cand;
   logic [NV-1:0] lowest;
   logic [VW-1:0] sel;
   logic          found;
   logic          edge_ok;
   logic [VW-1:0] edge_a;
   logic [VW-1:0] edge_b;

   assign live_n   = (32'(vertex_count_ff) > NV) ? CW'(NV) : CW'(vertex_count_ff);
   assign depth_m1 = depth_ff - CW'(1);
   assign top_idx  = depth_m1[VW-1:0];
   assign push_idx = depth_ff[VW-1:0];
   assign rd_idx   = cmd.rd_emit ? emit_ff : top_idx;
   assign rd_vertex = stack_ff[rd_idx];
   assign row      = adj_ff[rd_vertex];
   assign cur      = cursor_ff[top_idx];
   assign edge_ok  = (32'(req_data.from_vertex) < NV) && (32'(req_data.to_vertex) < NV);
   assign edge_a   = req_data.from_vertex[VW-1:0];
   assign edge_b   = req_data.to_vertex[VW-1:0];

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         cand[i] = row[i] && !visited_ff[i] && (i >= int'(cur)) && (i < int'(live_n));
      end
      lowest = cand & (~cand + NV'(1));
      sel    = '0;
      for (int i = 0; i < NV; i++) begin
         if (lowest[i]) begin
            sel = sel | VW'(i);
         end
      end
      found = |cand;
   end

   always_comb begin
      status.cfg_write    = csr_we && ((csr_index == CSR_VERTEX_COUNT) ||
                                       (csr_index == CSR_SOURCE_VERTEX) ||
                                       (csr_index == CSR_TARGET_VERTEX));
      status.endpoint_bad = (32'(source_ff) >= 32'(live_n)) ||
                            (32'(target_ff) >= 32'(live_n));
      status.src_is_tgt   = (source_ff == target_ff);
      status.stack_empty  = (depth_ff == '0);
      status.hit_target   = found && (32'(sel) == 32'(target_ff));
      status.emit_last    = ((CW'(emit_ff) + CW'(1)) == depth_ff);
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      vertex_count_in = vertex_count_ff;
      source_in       = source_ff;
      target_in       = target_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT:  vertex_count_in = csr_wdata[4:0];
            CSR_SOURCE_VERTEX: source_in       = csr_wdata[3:0];
            CSR_TARGET_VERTEX: target_in       = csr_wdata[3:0];
            default:           vertex_count_in = vertex_count_ff;
         endcase
      end
   end

   always_comb begin
      adj_in = adj_ff;
      if (cmd.adj_clear) begin
         for (int r = 0; r < NV; r++) begin
            adj_in[r] = '0;
         end
      end else if (cmd.adj_add && edge_ok) begin
         adj_in[edge_a][edge_b] = 1'b1;
         adj_in[edge_b][edge_a] = 1'b1;
      end
   end

   always_comb begin
      visited_in = visited_ff;
      stack_in   = stack_ff;
      cursor_in  = cursor_ff;
      depth_in   = depth_ff;
      if (cmd.walk_start) begin
         visited_in                     = '0;
         visited_in[source_ff[VW-1:0]]  = 1'b1;
         stack_in[0]                    = source_ff[VW-1:0];
         cursor_in[0]                   = '0;
         depth_in                       = CW'(1);
      end else if (cmd.walk_step && found) begin
         cursor_in[top_idx]  = CW'(sel) + CW'(1);
         stack_in[push_idx]  = sel;
         cursor_in[push_idx] = '0;
         visited_in[sel]     = 1'b1;
         depth_in            = depth_ff + CW'(1);
      end else if (cmd.walk_pop || cmd.walk_step) begin
         visited_in[rd_vertex] = 1'b0;
         depth_in              = depth_m1;
      end
   end

   always_comb begin
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_path) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.vertex_index = 4'(rd_vertex);
         rsp_data_in.last_of_path = status.emit_last;
         rsp_data_in.done_res     = 1'b0;
         emit_in                  = status.emit_last ? '0 : emit_ff + VW'(1);
      end else if (cmd.out_done) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.vertex_index = '0;
         rsp_data_in.last_of_path = 1'b0;
         rsp_data_in.done_res     = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
         source_ff       <= '0;
         target_ff       <= '0;
         adj_ff          <= '{default: '0};
         visited_ff      <= '0;
         depth_ff        <= '0;
         emit_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         source_ff       <= source_in;
         target_ff       <= target_in;
         adj_ff          <= adj_in;
         visited_ff      <= visited_in;
         depth_ff        <= depth_in;
         emit_ff         <= emit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stack_ff    <= stack_in;
      cursor_ff   <= cursor_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/all_simple_paths_enumerator.sv
// Add-edge and clear beats update the adjacency rows; a configuration write takes effect on the next cycle.
// A next-path beat starts or resumes the walk, then pushes or pops the walk stack step by step
// and sends each vertex of the path; the pushes and pops depend on the graph, with no small bound.
// The output register holds one beat, so the next request is taken while that beat waits.
// Synchronous reset empties the graph, loads the register defaults and restarts the walk;
// there is no clearing pass.
module all_simple_paths_enumerator #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  asp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output asp_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [asp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [asp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import asp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   asp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   asp_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/asp_checker.sv
// Port-level checker for the path enumerator, bound to the top level.
// Depends on asp_pkg and the assertion macros in all_simple_paths_enumerator_assert.svh.
`include "all_simple_paths_enumerator_assert.svh"

module asp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input asp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input asp_pkg::rsp_type rsp_data,
   input logic             csr_we
);
   import asp_pkg::*;

   `ASP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result beat changed or vanished")
   `ASP_ASSERT(a_cfg_no_beat, clock, reset, csr_we && !req_stall |=> !$rose(rsp_valid), "result beat started by a register write")
   `ASP_ASSERT(a_next_busy, clock, reset, req_valid && !req_stall && (req_data.command == CMD_NEXT_PATH) |=> req_stall, "next-path request did not occupy the block")
   `ASP_ASSERT(a_done_clean, clock, reset, rsp_valid && rsp_data.done_res |-> (rsp_data.vertex_index == 4'd0) && !rsp_data.last_of_path, "done beat carries a vertex")
   `ASP_ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind all_simple_paths_enumerator asp_checker u_asp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we)
);

FILE: tb/sv/path_tracker_pkg.sv
// Scoreboard for the all simple paths enumerator testbench: it follows the graph, the registers
// and the backtracking walk, and checks each result beat. Depends on asp_pkg.
package path_tracker_pkg;

   import asp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   class path_tracker;
      logic [15:0]    adj [16];
      logic [15:0]    visited;
      logic [3:0]     stack_v [16];
      logic [4:0]     cursor [16];
      int unsigned    depth;
      walk_phase_type phase;
      logic [4:0]     vcount;
      logic [3:0]     src;
      logic [3:0]     tgt;
      rsp_type        expected_vertices [$];
      int             errors;
      int             paths_seen;
      int             dones_seen;

      function new();
         foreach (adj[k]) adj[k] = '0;
         vcount     = VERTEX_COUNT_RESET;
         src        = '0;
         tgt        = '0;
         errors     = 0;
         paths_seen = 0;
         dones_seen = 0;
         restart();
      endfunction

      function void restart();
         visited = '0;
         foreach (stack_v[k]) begin
            stack_v[k] = '0;
            cursor[k]  = '0;
         end
         depth = 0;
         phase = PH_NOT_STARTED;
      endfunction

      function void push_vertex(logic [3:0] v);
         if (depth >= 16) return;
         stack_v[depth] = v;
         cursor[depth]  = '0;
         visited[v]     = 1'b1;
         depth++;
      endfunction

      function void pop_vertex();
         if (depth == 0) return;
         depth--;
         visited[stack_v[depth]] = 1'b0;
      endfunction

      function void expect_path();
         rsp_type beat;
         for (int unsigned k = 0; k < depth; k++) begin
            beat.vertex_index = stack_v[k];
            beat.last_of_path = (k + 1 == depth);
            beat.done_res     = 1'b0;
            expected_vertices.push_back(beat);
         end
         phase = PH_RESUME;
      endfunction

      function void expect_done();
         rsp_type beat;
         beat.vertex_index = '0;
         beat.last_of_path = 1'b0;
         beat.done_res     = 1'b1;
         expected_vertices.push_back(beat);
         phase = PH_FINISHED;
      endfunction

      // Starts or resumes the walk and queues the next source-to-target path, or a done beat.
      function void advance_walk();
         int unsigned n;
         int unsigned lvl;
         int unsigned i;
         logic [3:0]  v;
         bit          found;
         n = (vcount > 16) ? 16 : vcount;
         if (phase == PH_FINISHED) begin
            expect_done();
            return;
         end
         if (phase == PH_NOT_STARTED) begin
            restart();
            if (src >= n || tgt >= n) begin
               expect_done();
               return;
            end
            push_vertex(src);
            if (src == tgt) begin
               expect_path();
               return;
            end
         end else begin
            pop_vertex();
         end
         while (depth > 0) begin
            lvl   = depth - 1;
            v     = stack_v[lvl];
            found = 1'b0;
            for (i = cursor[lvl]; i < n; i++) begin
               if (adj[v][i] && !visited[i]) begin
                  found = 1'b1;
                  break;
               end
            end
            if (found) begin
               cursor[lvl] = 5'(i + 1);
               push_vertex(4'(i));
               if (i == tgt) begin
                  expect_path();
                  return;
               end
            end else begin
               cursor[lvl] = 5'(n);
               pop_vertex();
            end
         end
         expect_done();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_VERTEX_COUNT: vcount = value;
            CSR_SOURCE_VERTEX: src = value[3:0];
            CSR_TARGET_VERTEX: tgt = value[3:0];
            default: return;
         endcase
         restart();
      endfunction

      function void note_request(req_type r);
         case (r.command)
            CMD_ADD_EDGE: begin
               adj[r.from_vertex][r.to_vertex] = 1'b1;
               adj[r.to_vertex][r.from_vertex] = 1'b1;
               restart();
            end
            CMD_CLEAR: begin
               foreach (adj[k]) adj[k] = '0;
               restart();
            end
            CMD_NEXT_PATH: advance_walk();
            default: ;
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_vertex(rsp_type got);
         rsp_type want;
         if (expected_vertices.size() == 0) begin
            report($sformatf("beat with nothing expected: vertex %0d last %0b done %0b",
                             got.vertex_index, got.last_of_path, got.done_res));
            return;
         end
         want = expected_vertices.pop_front();
         if (got.vertex_index !== want.vertex_index)
            report($sformatf("vertex_index %0d, expected %0d", got.vertex_index,
                             want.vertex_index));
         if (got.last_of_path !== want.last_of_path)
            report($sformatf("last_of_path %0b, expected %0b", got.last_of_path,
                             want.last_of_path));
         if (got.done_res !== want.done_res)
            report($sformatf("done_res %0b, expected %0b", got.done_res, want.done_res));
         if (want.done_res) dones_seen++;
         else if (want.last_of_path) paths_seen++;
      endtask
   endclass

endpackage

FILE: tb/sv/tb.sv
// Top-level testbench for all_simple_paths_enumerator: directed and random graphs, register
// settings and path requests, with random idling on both channels. Depends on asp_pkg and
// path_tracker_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import asp_pkg::*;
   import path_tracker_pkg::*;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   path_tracker tracker = new();
   bit          calm = 1'b0;
   int          beats_sent = 0;
   int          reg_writes = 0;

   all_simple_paths_enumerator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_vertex(rsp_data);
   end

   initial begin : rsp_stall_bursts
      int n;
      forever begin
         n = $urandom_range(1, 40);
         repeat (n) @(negedge clock);
         if (!calm) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 15);
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send(input logic [1:0] cmd, input logic [3:0] a, input logic [3:0] b);
      req_type item;
      int      gap;
      item.command     = cmd;
      item.from_vertex = a;
      item.to_vertex   = b;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_request(item);
      if (cmd != CMD_UNUSED) beats_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(index, value);
      reg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_vertices.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_vertex(input int unsigned live);
      if (live == 0 || $urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, live - 1));
   endfunction

   initial begin : stimulus
      int          directed_beats;
      int unsigned live;
      logic [4:0]  count;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      send(CMD_NEXT_PATH, 4'd15, 4'd15);
      send(CMD_UNUSED, 4'd15, 4'd15);
      send(CMD_NEXT_PATH, 4'd5, 4'd10);
      send(CMD_ADD_EDGE, 4'd15, 4'd15);
      for (int k = 0; k < 15; k++) send(CMD_ADD_EDGE, 4'(k), 4'(k + 1));
      drain(16);
      write_reg(CSR_TARGET_VERTEX, 5'd15);
      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      drain(16);
      write_reg(CSR_VERTEX_COUNT, 5'd0);
      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      drain(16);
      write_reg(CSR_VERTEX_COUNT, 5'd31);
      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      drain(16);
      write_reg(CSR_SOURCE_VERTEX, 5'd15);
      write_reg(CSR_TARGET_VERTEX, 5'd0);
      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      send(CMD_CLEAR, 4'd9, 4'd6);
      send(CMD_NEXT_PATH, 4'd0, 4'd0);
      directed_beats = beats_sent;

      while (beats_sent - directed_beats < 70) begin
         calm = (beats_sent - directed_beats >= 55);
         drain(16);
         case ($urandom_range(0, 9))
            0: count = 5'd0;
            1: count = 5'd1;
            2: count = ($urandom_range(0, 1) == 0) ? 5'd16 : 5'($urandom_range(17, 31));
            default: count = 5'($urandom_range(2, 6));
         endcase
         live = (count > 16) ? 16 : count;
         write_reg(CSR_VERTEX_COUNT, count);
         write_reg(CSR_SOURCE_VERTEX, {1'($urandom_range(0, 1)), pick_vertex(live)});
         write_reg(CSR_TARGET_VERTEX, {1'($urandom_range(0, 1)), pick_vertex(live)});
         if (live > 6) begin
            // Large graphs stay a chain with a few chords so the search stays short.
            send(CMD_CLEAR, 4'($urandom), 4'($urandom));
            for (int k = 0; k < 15; k++) begin
               if ($urandom_range(0, 1) == 0) send(CMD_ADD_EDGE, 4'(k), 4'(k + 1));
               else send(CMD_ADD_EDGE, 4'(k + 1), 4'(k));
            end
            repeat ($urandom_range(0, 2))
               send(CMD_ADD_EDGE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end else begin
            if ($urandom_range(0, 2) == 0) send(CMD_CLEAR, 4'($urandom), 4'($urandom));
            repeat ($urandom_range(0, 6)) send(CMD_ADD_EDGE, pick_vertex(live), pick_vertex(live));
         end
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 5) == 0) begin
               if ($urandom_range(0, 1) == 0) send(CMD_UNUSED, 4'($urandom), 4'($urandom));
               else send(CMD_ADD_EDGE, pick_vertex(live), pick_vertex(live));
            end
            send(CMD_NEXT_PATH, 4'($urandom), 4'($urandom));
         end
      end

      drain(300);
      $display("Sent %0d request beats and %0d register writes; checked %0d paths and %0d done beats.",
               beats_sent, reg_writes, tracker.paths_seen, tracker.dones_seen);
      if (tracker.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
